// ----- rtl/isc_pkg.sv -----
// ============================================================================
// isc_pkg: shared types and constants of the insertion sorter
// Holds the field widths, the control word that drives the sorting cells and
// the state type of the sequencer.
// ============================================================================
package isc_pkg;

    // Width of one data word and of the inversion count.
    localparam int VALUE_W = 32;
    localparam int SHIFT_W = 11;

    // The shift-count tree sums comparison bits in groups of this size.
    localparam int GROUP_W = 8;

    // Operation applied to every cell of the chain in the same cycle.
    typedef struct packed {
        logic insert;   // place the incoming word, larger words move up
        logic drain;    // every cell takes the word of the cell above; the top cell keeps its own
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_FILL,        // taking words of a list
        ST_SETTLE,      // shift-count pipeline finishes the last insert
        ST_DRAIN        // sorted words leave from the bottom of the chain
    } state_t;

endpackage

// ----- rtl/isc_cell.sv -----
// ============================================================================
// isc_cell: one place of the sorting chain
// Holds one stored word. On an insert it keeps its word, takes the new word or
// takes the word of the cell below; on a drain it takes the word from above.
// ============================================================================
module isc_cell
    import isc_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
)
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic [CNT_W-1:0]          count,
    input  logic signed [VALUE_W-1:0] ins_value,
    input  logic signed [VALUE_W-1:0] lower_value,
    input  logic                      lower_above,
    input  logic signed [VALUE_W-1:0] upper_value,
    output logic signed [VALUE_W-1:0] value,
    output logic                      above,
    output logic                      gt
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      occupied;

    // The cell holds a word of the list when its place is below the fill count.
    assign occupied = (count > CNT_W'(IDX));
    assign gt       = occupied && (value_reg > ins_value);
    // A free cell sits above the new word as well as a larger stored one.
    assign above    = !occupied || gt;
    assign value    = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.drain)
        begin
            value_next = upper_value;
        end
        else if (ctrl.insert && above)
        begin
            value_next = lower_above ? lower_value : ins_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- rtl/isc_shift_counter.sv -----
// ============================================================================
// isc_shift_counter: running inversion count
// Counts the cells that move up on each insert and adds them to the total,
// through a registered comparison mask and registered group sums.
// ============================================================================
module isc_shift_counter
    import isc_pkg::*;
#(
    parameter int MAX_ITEMS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 insert,
    input  logic [MAX_ITEMS-1:0] gt_mask,
    input  logic                 clear,
    output logic [SHIFT_W-1:0]   total
);

    localparam int NGRP   = (MAX_ITEMS + GROUP_W - 1) / GROUP_W;
    localparam int PART_W = $clog2(GROUP_W + 1);

    logic [NGRP*GROUP_W-1:0]       mask_reg;
    logic [NGRP*GROUP_W-1:0]       mask_next;
    logic [NGRP-1:0][PART_W-1:0]   part_reg;
    logic [NGRP-1:0][PART_W-1:0]   part_next;
    logic [SHIFT_W-1:0]            total_reg;
    logic [SHIFT_W-1:0]            total_next;
    logic [SHIFT_W-1:0]            part_sum;

    always_comb
    begin
        mask_next = '0;
        if (insert)
        begin
            mask_next[MAX_ITEMS-1:0] = gt_mask;
        end
    end

    // Each group of comparison bits is counted on its own.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            part_next[g] = '0;
            for (int b = 0; b < GROUP_W; b++)
            begin
                part_next[g] = part_next[g] + PART_W'(mask_reg[g*GROUP_W + b]);
            end
        end
    end

    always_comb
    begin
        part_sum = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            part_sum = part_sum + SHIFT_W'(part_reg[g]);
        end
    end

    // The total never passes 2016 for a chain of at most 64 cells.
    assign total_next = clear ? '0 : (total_reg + part_sum);
    assign total      = total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            part_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            mask_reg  <= mask_next;
            part_reg  <= part_next;
            total_reg <= total_next;
        end
    end

endmodule

// ----- rtl/insertion_sorter_with_shift_count.sv -----
// ============================================================================
// insertion_sorter_with_shift_count: systolic insertion sorter
// Sorts a list of signed words in a chain of cells, counts the inversions and
// sends the list out in ascending order after its last word.
// ============================================================================
//
//  Channel  Handshake             Payload
//  -------  --------------------  ------------------------------------------
//  input    in_valid / in_stall   value, last
//  output   out_valid / out_stall sorted_value, last_res, shift_count, overflow
//
// While a list is being collected, one word is taken in every cycle. After the
// last word the block stalls its input while the shift-count pipeline settles,
// then sends one sorted word per cycle from the bottom of the chain whenever
// the output is not stalled.
// Reset empties the chain and clears the count and the overflow flag. A stall
// on the output only holds the output register; the chain waits with it.
//
// Each cell compares its word against the incoming word in parallel. Cells
// that hold a larger word move up by one place, and the first of them takes
// the new word, so equal words keep their order of arrival. The number of
// cells that moved is added to the running shift count, which is then the
// number of inversions in the list. A word that arrives when all MAX_ITEMS
// cells are full is dropped and sets the overflow flag; a dropped last word
// still starts the output of the list. Every output word carries the final
// shift count and overflow flag, and the largest word is marked with last_res.
// After the list has left, the count and the flag go back to zero.
//
module insertion_sorter_with_shift_count
    import isc_pkg::*;
#(
    parameter int MAX_ITEMS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] sorted_value,
    output logic                      last_res,
    output logic [SHIFT_W-1:0]        shift_count,
    output logic                      overflow
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    state_t                    state_reg;
    state_t                    state_next;
    logic                      settle_reg;
    logic                      settle_next;
    logic [CNT_W-1:0]          fill_reg;
    logic [CNT_W-1:0]          fill_next;
    logic                      drop_reg;
    logic                      drop_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_last_reg;
    logic [SHIFT_W-1:0]        out_shift_reg;
    logic                      out_ovf_reg;

    logic                      in_accept;
    logic                      full;
    logic                      load;
    logic                      count_clear;
    cell_ctrl_t                ctrl;
    logic [SHIFT_W-1:0]        shift_total;

    logic signed [VALUE_W-1:0] cell_value [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]      cell_above;
    logic [MAX_ITEMS-1:0]      cell_gt;

    assign full      = (fill_reg == CNT_W'(MAX_ITEMS));
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        settle_next = settle_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (in_valid && last)
                begin
                    state_next  = ST_SETTLE;
                    settle_next = 1'b0;
                end
            end
            ST_SETTLE:
            begin
                settle_next = 1'b1;
                if (settle_reg)
                begin
                    state_next  = ST_DRAIN;
                    settle_next = 1'b0;
                end
            end
            ST_DRAIN:
            begin
                // The chain is never empty here; the guard only keeps the
                // sequencer from hanging.
                if (fill_reg == '0)
                begin
                    state_next = ST_FILL;
                end
                else if (load && (fill_reg == CNT_W'(1)))
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        in_stall    = 1'b1;
        load        = 1'b0;
        ctrl.insert = 1'b0;
        ctrl.drain  = 1'b0;
        count_clear = 1'b0;
        unique case (state_reg)
            ST_FILL:
            begin
                in_stall    = 1'b0;
                ctrl.insert = in_valid && !full;
            end
            ST_SETTLE:
            begin
                in_stall = 1'b1;
            end
            ST_DRAIN:
            begin
                load        = (fill_reg != '0) && (!out_valid_reg || !out_stall);
                ctrl.drain  = load;
                count_clear = load && (fill_reg == CNT_W'(1));
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Fill count and overflow flag
    // ------------------------------------------------------------------------
    always_comb
    begin
        fill_next = fill_reg;
        drop_next = drop_reg;
        if (in_accept)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        else if (load)
        begin
            fill_next = fill_reg - CNT_W'(1);
            if (count_clear)
            begin
                drop_next = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Chain of sorting cells, cell 0 holds the smallest word
    // ------------------------------------------------------------------------
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] lower_value;
        logic                      lower_above;
        logic signed [VALUE_W-1:0] upper_value;

        if (i == 0)
        begin : g_bottom
            assign lower_value = '0;
            assign lower_above = 1'b0;
        end
        else
        begin : g_mid_low
            assign lower_value = cell_value[i-1];
            assign lower_above = cell_above[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_top
            assign upper_value = cell_value[i];
        end
        else
        begin : g_mid_high
            assign upper_value = cell_value[i+1];
        end

        isc_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (fill_reg),
            .ins_value   (value),
            .lower_value (lower_value),
            .lower_above (lower_above),
            .upper_value (upper_value),
            .value       (cell_value[i]),
            .above       (cell_above[i]),
            .gt          (cell_gt[i])
        );
    end

    // ------------------------------------------------------------------------
    // Inversion count
    // ------------------------------------------------------------------------
    isc_shift_counter #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_shift_counter (
        .clk     (clk),
        .rst_n   (rst_n),
        .insert  (ctrl.insert),
        .gt_mask (cell_gt),
        .clear   (count_clear),
        .total   (shift_total)
    );

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_value_reg <= cell_value[0];
            out_last_reg  <= (fill_reg == CNT_W'(1));
            out_shift_reg <= shift_total;
            out_ovf_reg   <= drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            settle_reg    <= 1'b0;
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            settle_reg    <= settle_next;
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign last_res     = out_last_reg;
    assign shift_count  = out_shift_reg;
    assign overflow     = out_ovf_reg;

endmodule

// ----- tb/sorted_list_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// sorted_list_checker: scoreboard for the insertion sorter
// Watches both channels of the sorter, keeps its own sorted copy of each list
// with the inversion count and overflow flag, and compares every output word
// against the oldest word still due.
// ============================================================================
module sorted_list_checker
    import isc_pkg::*;
#(
    parameter int MAX_ITEMS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      last,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic signed [VALUE_W-1:0] sorted_value,
    input  logic                      last_res,
    input  logic [SHIFT_W-1:0]        shift_count,
    input  logic                      overflow,
    output int                        mismatch_count,
    output int                        words_due
);

    localparam int SHIFT_LIMIT = (1 << SHIFT_W) - 1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic [SHIFT_W-1:0]        shifts;
        logic                      dropped;
    } sorted_word_t;

    // Current list, kept in ascending order.
    logic signed [VALUE_W-1:0] held [MAX_ITEMS];
    int                        held_count = 0;
    int                        inversions = 0;
    logic                      drop_seen = 1'b0;

    sorted_word_t sorted_due[$];
    int           mismatches = 0;

    // Larger words move up one place; an equal word stays below the newcomer.
    function automatic void insert_word(input logic signed [VALUE_W-1:0] v);
        int pos;
        int moved;
        pos = held_count;
        moved = 0;
        if (held_count >= MAX_ITEMS)
        begin
            drop_seen = 1'b1;
        end
        else
        begin
            while (pos > 0 && held[pos-1] > v)
            begin
                held[pos] = held[pos-1];
                pos--;
                moved++;
            end
            held[pos] = v;
            held_count++;
            inversions += moved;
            if (inversions > SHIFT_LIMIT)
                inversions = SHIFT_LIMIT;
        end
    endfunction

    function automatic void release_list();
        sorted_word_t w;
        for (int k = 0; k < held_count; k++)
        begin
            w.value = held[k];
            w.last = (k == held_count - 1);
            w.shifts = inversions[SHIFT_W-1:0];
            w.dropped = drop_seen;
            sorted_due.push_back(w);
        end
        held_count = 0;
        inversions = 0;
        drop_seen = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sorted_word_t got;
        sorted_word_t want;
        if (!rst_n)
        begin
            held_count = 0;
            inversions = 0;
            drop_seen = 1'b0;
            sorted_due.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                insert_word(value);
                if (last)
                    release_list();
            end
            if (out_valid && !out_stall)
            begin
                got.value = sorted_value;
                got.last = last_res;
                got.shifts = shift_count;
                got.dropped = overflow;
                if (sorted_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected word value=%0d last=%0b shifts=%0d ovf=%0b",
                                 $realtime, got.value, got.last, got.shifts, got.dropped);
                end
                else
                begin
                    want = sorted_due.pop_front();
                    if (got.value !== want.value || got.last !== want.last ||
                        got.shifts !== want.shifts || got.dropped !== want.dropped)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: mismatch expected value=%0d last=%0b shifts=%0d",
                                      " ovf=%0b, got value=%0d last=%0b shifts=%0d ovf=%0b"},
                                     $realtime, want.value, want.last, want.shifts,
                                     want.dropped, got.value, got.last, got.shifts,
                                     got.dropped);
                    end
                end
            end
        end
        mismatch_count <= mismatches;
        words_due <= sorted_due.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench of the insertion sorter with shift count
// Feeds lists of signed words, directed ones first and then random lists of
// varied shapes, with random gaps and output stalls. A checker module beside
// the sorter predicts every sorted word and reports mismatches.
// ============================================================================
module tb_top
    import isc_pkg::*;
();

    localparam int MAX_ITEMS = 32;
    localparam int RANDOM_WORDS = 460;
    localparam int MAX_GAP = 5;
    // Cycles with no word accepted on either channel before the run is given
    // up. In a correct run the longest such stretch is the quiet wait at the
    // very end.
    localparam int IDLE_LIMIT = 1000;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    // Shapes of the random lists. Rising and falling lists give the fewest
    // and the most inversions, repeats exercise the stable order of equal
    // words, and extremes hit the ends of the signed range.
    typedef enum int {
        SHAPE_SCATTER,
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_REPEATS,
        SHAPE_EXTREMES
    } list_shape_t;

    // Every input of the sorter has a known value from time zero.
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      last = 1'b0;
    logic                      out_stall = 1'b0;

    logic                      in_stall;
    logic                      out_valid;
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_res;
    logic [SHIFT_W-1:0]        shift_count;
    logic                      overflow;

    int mismatch_count;
    int words_due;

    // When set, neither side idles, which gives back-to-back stretches.
    bit no_idle = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;
    int words_sent = 0;

    always #2 clk = ~clk;

    insertion_sorter_with_shift_count #(
        .MAX_ITEMS (MAX_ITEMS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .last_res     (last_res),
        .shift_count  (shift_count),
        .overflow     (overflow)
    );

    sorted_list_checker #(
        .MAX_ITEMS (MAX_ITEMS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sorted_value   (sorted_value),
        .last_res       (last_res),
        .shift_count    (shift_count),
        .overflow       (overflow),
        .mismatch_count (mismatch_count),
        .words_due      (words_due)
    );

    // Output side. After each accepted word the receiver draws a random stall,
    // which may be empty. Between words it also stalls now and then on its
    // own, so that stalls also land on the first word of a list and on the
    // settling cycles after the last input word.
    always @(posedge clk or negedge rst_n)
    begin
        int rx_gap;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            rx_gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            stall_left <= rx_gap;
            out_stall <= (rx_gap > 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end
        else if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, MAX_GAP - 1);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one word. The gap before it is drawn per word; in_valid is only
    // lowered when there is a gap, so it is assigned once per clock edge.
    // Returns at the edge where the word was accepted.
    task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic is_last);
        int tx_gap;
        tx_gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (tx_gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (tx_gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        last <= is_last;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic send_list(input int len, input list_shape_t shape);
        logic signed [VALUE_W-1:0] base;
        logic signed [VALUE_W-1:0] v;
        int step;
        base = $signed($urandom_range(0, 2000)) - 1000;
        step = $urandom_range(1, 3);
        for (int k = 0; k < len; k++)
        begin
            case (shape)
                SHAPE_RISING:   v = base + k * step;
                SHAPE_FALLING:  v = base - k * step;
                SHAPE_REPEATS:  v = $signed($urandom_range(0, 6)) - 3;
                SHAPE_EXTREMES:
                begin
                    case ($urandom_range(0, 4))
                        0:       v = VALUE_MIN;
                        1:       v = VALUE_MAX;
                        2:       v = '0;
                        3:       v = -1;
                        default: v = $urandom;
                    endcase
                end
                default:        v = $urandom;
            endcase
            send_word(v, k == len - 1);
        end
    endtask

    // Holds the input idle until every predicted word has come out. The first
    // edge lets the checker take in a last word accepted at this very edge.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int list_idx;
        int len;
        int random_start;
        list_shape_t shape;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A list of one word, at the top of the signed range.
        send_word(VALUE_MAX, 1'b1);

        // Both extremes, zero twice, minus one and one: six inversions.
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(VALUE_MAX, 1'b0);
        send_word(VALUE_MIN, 1'b0);
        send_word(0, 1'b0);
        send_word(1, 1'b1);

        // Strictly falling list: every pair is an inversion.
        for (int k = 0; k < 8; k++)
            send_word(7 - k, k == 7);

        // Alternating bit patterns, one of them negative.
        send_word(32'sh5555_5555, 1'b0);
        send_word(32'shAAAA_AAAA, 1'b1);

        // Equal words only: nothing moves.
        for (int k = 0; k < 3; k++)
            send_word(-5, k == 2);

        // The sender pauses here until every expected word has arrived.
        wait_for_results();

        // Random lists. Every twelfth list fills the store exactly with a
        // falling run, which gives the most shifts; another drops its last
        // word on a full store. Most lists are short.
        list_idx = 0;
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS)
        begin
            no_idle <= ($urandom_range(0, 4) == 0);
            shape = list_shape_t'($urandom_range(0, 4));
            if (list_idx % 12 == 11)
            begin
                len = MAX_ITEMS;
                shape = SHAPE_FALLING;
            end
            else if (list_idx % 12 == 5)
            begin
                len = MAX_ITEMS + 1;
            end
            else if ($urandom_range(0, 99) < 70)
            begin
                len = $urandom_range(1, 12);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                len = $urandom_range(13, MAX_ITEMS - 1);
            end
            else
            begin
                len = $urandom_range(MAX_ITEMS, MAX_ITEMS + 8);
            end
            send_list(len, shape);
            if (list_idx == 10)
                wait_for_results();
            list_idx++;
        end

        // Drain, then give the sorter time for a full list plus settling in
        // case it sends anything that was not expected.
        no_idle <= 1'b0;
        wait_for_results();
        repeat (MAX_ITEMS + 4) @(posedge clk);

        if (mismatch_count == 0 && words_due == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/isc_pkg.sv
rtl/isc_cell.sv
rtl/isc_shift_counter.sv
rtl/insertion_sorter_with_shift_count.sv
tb/sorted_list_checker.sv
tb/tb_top.sv
